[hw/rtl/bfr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Brace frame receiver package
// Constants, widths and the command and status words that pass between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package bfr_pkg;

  // Largest number of payload characters held for one frame.
  localparam int MAX_PAYLOAD = 10;

  // Index into the payload store and count of stored characters.
  localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

  // Width of the byte_index port.
  localparam int BYTE_INDEX_W = 4;

  // Framing characters.
  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_CLOSE = 8'h7D;

  // Input word kinds.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // An input word is taken this cycle.
    logic load_out;  // Load the next result into the output register.
  } bfr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit_start;  // The word at the input is a quiet tick with a frame ready.
    logic emit_last;   // The next result to load is the last of the frame.
  } bfr_status_t;

endpackage
`default_nettype wire

[hw/rtl/brace_frame_receiver.sv]
`timescale 1ns / 1ps
`default_nettype none
// Timing: a quiet tick that ends a burst with a frame ready moves the
// controller to its emit state, which then loads the first result into the
// output register. Throughput: one input word per cycle while receiving. A
// frame of N payload bytes (one result if empty) holds the input stalled until
// its last result is loaded; results are loaded one per cycle when not stalled.
// Reset (rst, synchronous) returns to idle with no frame pending.
// ----------------------------------------------------------------------------
// Brace frame receiver
// Parses '{' type payload '}' frames from a byte stream and emits the payload
// of a completed frame, one word per character, when its burst ends.
// ----------------------------------------------------------------------------
module brace_frame_receiver
  import bfr_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    kind,
  input  wire logic [7:0]              rx_byte,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [7:0]                   frame_type,
  output logic [7:0]                   payload_byte,
  output logic                         byte_valid,
  output logic [BYTE_INDEX_W-1:0]      byte_index,
  output logic                         is_last
);

  bfr_cmd_t    cmd;
  bfr_status_t status;

  // Controller.
  bfr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // Datapath.
  bfr_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .kind         (kind),
    .rx_byte      (rx_byte),
    .frame_type   (frame_type),
    .payload_byte (payload_byte),
    .byte_valid   (byte_valid),
    .byte_index   (byte_index),
    .is_last      (is_last)
  );

  // An empty payload is reported as one final word at index zero.
  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !byte_valid) |-> (is_last && byte_index == '0 && payload_byte == '0))
    else $error("empty payload word malformed");

  // While more words of a frame remain, the input is held off.
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_last) |-> in_stall)
    else $error("input open while frame words remain");

  // During an emission an empty output register is filled on the next cycle.
  a_emit_progress: assert property (@(posedge clk) disable iff (rst)
    (in_stall && !out_valid) |=> out_valid)
    else $error("output register not filled during emission");

  // Result positions stay within the payload store.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_index < BYTE_INDEX_W'(MAX_PAYLOAD)))
    else $error("byte index out of range");

endmodule
`default_nettype wire

[hw/rtl/bfr_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Brace frame receiver datapath
// Frame parsing state, payload store, burst tracking and the output register
// that presents one result word at a time.
// ----------------------------------------------------------------------------
module bfr_datapath
  import bfr_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire bfr_cmd_t                cmd,
  output bfr_status_t                  status,
  input  wire logic                    kind,
  input  wire logic [7:0]              rx_byte,
  output logic [7:0]                   frame_type,
  output logic [7:0]                   payload_byte,
  output logic                         byte_valid,
  output logic [BYTE_INDEX_W-1:0]      byte_index,
  output logic                         is_last
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HUNT,
    PH_TYPE,
    PH_DATA
  } phase_t;

  phase_t             phase;
  logic [LEN_W-1:0]   payload_count;
  logic [7:0]         payload_store [MAX_PAYLOAD];
  logic [7:0]         type_held;
  logic               byte_seen;
  logic               frame_ready;
  logic [LEN_W-1:0]   ready_length;
  logic [IDX_W-1:0]   emit_idx;

  logic take_byte;
  logic take_tick;
  logic store_we;

  assign take_byte = cmd.accept && (kind == KIND_BYTE);
  assign take_tick = cmd.accept && (kind == KIND_TICK);

  // A payload character is stored while in the data phase, below the limit.
  assign store_we = take_byte && !frame_ready && (phase == PH_DATA) &&
                    (rx_byte != CH_CLOSE) && (payload_count < LEN_W'(MAX_PAYLOAD));

  // Status toward the controller.
  assign status.emit_start = (kind == KIND_TICK) && (phase != PH_IDLE) &&
                             !byte_seen && frame_ready;
  assign status.emit_last  = (ready_length == '0) ||
                             ((LEN_W'(emit_idx) + LEN_W'(1)) == ready_length);

  // Frame parsing and burst tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      payload_count <= '0;
      type_held     <= '0;
      byte_seen     <= 1'b0;
      frame_ready   <= 1'b0;
      ready_length  <= '0;
      emit_idx      <= '0;
    end else begin
      if (take_byte) begin
        byte_seen <= 1'b1;
        if (!frame_ready) begin
          unique case (phase)
            PH_IDLE, PH_HUNT: begin
              if (rx_byte == CH_OPEN) begin
                phase         <= PH_TYPE;
                payload_count <= '0;
              end else begin
                phase <= PH_HUNT;
              end
            end
            PH_TYPE: begin
              type_held <= rx_byte;
              phase     <= PH_DATA;
            end
            PH_DATA: begin
              if (rx_byte == CH_CLOSE) begin
                frame_ready   <= 1'b1;
                ready_length  <= payload_count;
                payload_count <= '0;
                phase         <= PH_HUNT;
              end else if (payload_count >= LEN_W'(MAX_PAYLOAD)) begin
                // Overlong payload: drop the frame and hunt again.
                payload_count <= '0;
                phase         <= PH_HUNT;
              end else begin
                payload_count <= payload_count + LEN_W'(1);
              end
            end
            default: begin
              phase <= PH_IDLE;
            end
          endcase
        end
      end else if (take_tick && (phase != PH_IDLE)) begin
        if (byte_seen) begin
          byte_seen <= 1'b0;
        end else begin
          // Quiet tick ends the burst; a ready frame is emitted afterwards.
          phase         <= PH_IDLE;
          payload_count <= '0;
        end
      end

      // Step through the ready frame while results are loaded.
      if (cmd.load_out) begin
        if (status.emit_last) begin
          emit_idx     <= '0;
          frame_ready  <= 1'b0;
          ready_length <= '0;
        end else begin
          emit_idx <= emit_idx + IDX_W'(1);
        end
      end
    end
  end

  // Payload store, written one character at a time.
  always_ff @(posedge clk) begin
    if (store_we) begin
      payload_store[payload_count[IDX_W-1:0]] <= rx_byte;
    end
  end

  // Output register, loaded with one result word per command.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      frame_type <= type_held;
      is_last    <= status.emit_last;
      if (ready_length == '0) begin
        payload_byte <= '0;
        byte_valid   <= 1'b0;
        byte_index   <= '0;
      end else begin
        payload_byte <= payload_store[emit_idx];
        byte_valid   <= 1'b1;
        byte_index   <= BYTE_INDEX_W'(emit_idx);
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/bfr_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Brace frame receiver controller
// Accepts input words while receiving and walks the output register through
// the results of a completed frame once its burst has ended.
// ----------------------------------------------------------------------------
module bfr_ctrl
  import bfr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  wire logic         out_stall,
  output bfr_cmd_t          cmd,
  input  wire bfr_status_t  status
);

  typedef enum logic {
    S_RECV,
    S_EMIT
  } state_t;

  state_t state;
  logic   load_ok;

  // Input is held off while results of a frame are being produced.
  assign in_stall     = (state == S_EMIT);
  assign load_ok      = !out_valid || !out_stall;
  assign cmd.accept   = in_valid && !in_stall;
  assign cmd.load_out = (state == S_EMIT) && load_ok;

  // State and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RECV;
      out_valid <= 1'b0;
    end else begin
      // The output word is set on a load and cleared once it is taken.
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_RECV: begin
          if (cmd.accept && status.emit_start) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (load_ok && status.emit_last) begin
            state <= S_RECV;
          end
        end
        default: begin
          state <= S_RECV;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
